FILE: hw/rtl/tcs_pkg.sv
// Shared types and constants of the trajectory checkpoint sequencer.
package tcs_pkg;

   // Command codes carried in the op field of an input word.
   localparam logic [3:0] OP_TICK    = 4'd0;
   localparam logic [3:0] OP_ARM     = 4'd1;
   localparam logic [3:0] OP_START   = 4'd2;
   localparam logic [3:0] OP_PAUSE   = 4'd3;
   localparam logic [3:0] OP_RESUME  = 4'd4;
   localparam logic [3:0] OP_STOP    = 4'd5;
   localparam logic [3:0] OP_RESET   = 4'd6;
   localparam logic [3:0] OP_PASS    = 4'd7;
   localparam logic [3:0] OP_FAIL    = 4'd8;
   localparam logic [3:0] OP_APPEND  = 4'd9;

   // Playback status codes reported in run_status.
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_READY    = 3'd1;
   localparam logic [2:0] ST_RUNNING  = 3'd2;
   localparam logic [2:0] ST_PAUSED   = 3'd3;
   localparam logic [2:0] ST_FINISHED = 3'd4;
   localparam logic [2:0] ST_ERROR    = 3'd5;

   // Register map: index of each register in the word address space.
   localparam int         CSR_ADDR_W         = 4;
   localparam logic [1:0] REG_TOTAL_DURATION = 2'd0;
   localparam logic [1:0] REG_VERIFY_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_FAIL_LIMIT     = 2'd2;

   // Register reset values and saturation limits.
   localparam logic [31:0] TOTAL_DURATION_RST = 32'd0;
   localparam logic [31:0] VERIFY_TIMEOUT_RST = 32'd1000000;
   localparam logic [7:0]  FAIL_LIMIT_RST     = 8'd10;
   localparam logic [31:0] TIME_MAX           = 32'hFFFF_FFFF;
   localparam logic [7:0]  FAIL_MAX           = 8'hFF;

   // Configuration as seen by the sequencer.
   typedef struct packed {
      logic [31:0] total_duration;
      logic [31:0] verify_timeout;
      logic [7:0]  fail_limit;
   } cfg_type;

   // Status of the checkpoint search unit.
   typedef struct packed {
      logic done;
      logic hit;
   } srch_stat_type;

   // Command sequencer states.
   typedef enum logic [3:0] {
      F_IDLE   = 4'b0001,
      F_EXEC   = 4'b0010,
      F_SEARCH = 4'b0100,
      F_DONE   = 4'b1000
   } seq_state_type;

endpackage

FILE: hw/rtl/tcs_req_if.sv
// Command channel interface: one command word per handshake.
interface tcs_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  op;
   logic [15:0] dt;
   logic [31:0] point_time;

   modport source (output valid, output op, output dt, output point_time, input ready);
   modport sink (input valid, input op, input dt, input point_time, output ready);
endinterface

FILE: hw/rtl/tcs_rsp_if.sv
// Status channel interface: one status word per handshake.
interface tcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  run_status;
   logic        accepted;
   logic        waiting;
   logic [31:0] play_time;
   logic [7:0]  fail_count;

   modport source (output valid, output run_status, output accepted, output waiting,
                   output play_time, output fail_count, input ready);
   modport sink (input valid, input run_status, input accepted, input waiting,
                 input play_time, input fail_count, output ready);
endinterface

FILE: hw/rtl/trajectory_checkpoint_sequencer.sv
// Top level of the trajectory checkpoint sequencer: command sequencer and ports.
//
// The req channel carries one command word (op, dt, point_time) per
// valid/ready handshake; the rsp channel returns exactly one status word
// (run_status, accepted, waiting, play_time, fail_count) for each command,
// in order. Registers total_duration, verify_timeout and fail_limit sit on
// the csr APB port at byte addresses 0, 4 and 8; the user is to have them
// written only while the block is idle, which the block does not enforce.
// A command is executed in the cycle after it is taken, and its status word
// is then loaded into the output register from the done state. A tick that
// moves the play time without finishing first searches the checkpoint table,
// one entry per cycle through a single read port and comparator.
// req ready is high only while no command is in flight, so a new command is
// taken as soon as the previous status word sits in the output register.
// If rsp stalls, that word is held and the next command waits after
// execution until the register frees up. Synchronous reset returns to idle,
// restores the register defaults and empties the checkpoint table.
module trajectory_checkpoint_sequencer #(
   parameter int MAX_POINTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   tcs_req_if.sink                         req,
   tcs_rsp_if.source                       rsp
);

   tcs_pkg::cfg_type       cfg;
   tcs_pkg::srch_stat_type srch_stat;
   tcs_pkg::seq_state_type seq_ff, seq_in;

   logic [3:0]  cmd_op_ff;
   logic [15:0] cmd_dt_ff;
   logic [31:0] cmd_pt_ff;

   logic [2:0]  run_state_ff, run_state_in;
   logic [31:0] cur_time_ff, cur_time_in;
   logic        hold_ff, hold_in;
   logic [31:0] hold_time_ff, hold_time_in;
   logic [31:0] wait_ff, wait_in;
   logic [7:0]  fail_ff, fail_in;
   logic        acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic        rsp_acc_ff;
   logic        rsp_wait_ff;
   logic [31:0] rsp_time_ff;
   logic [7:0]  rsp_fail_ff;

   logic        req_take;
   logic        load_rsp;
   logic        do_clear;
   logic        append_en;
   logic        clear_en;
   logic        srch_start;
   logic        table_full;
   logic [32:0] tick_sum;
   logic [31:0] wait_sat;
   logic [7:0]  fail_inc;

   // Configuration registers.
   tcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Checkpoint table and serial search.
   tcs_point_mem #(
      .MAX_POINTS (MAX_POINTS)
   ) u_point_mem (
      .clock        (clock),
      .reset        (reset),
      .append_en    (append_en),
      .append_data  (cmd_pt_ff),
      .clear_en     (clear_en),
      .search_start (srch_start),
      .search_key   (cur_time_ff),
      .full         (table_full),
      .stat         (srch_stat)
   );

   assign req.ready = (seq_ff == tcs_pkg::F_IDLE);
   assign req_take  = req.valid && req.ready;

   // One adder serves both the wait accumulation and the time advance.
   assign tick_sum = {1'b0, (hold_ff ? wait_ff : cur_time_ff)} + {17'd0, cmd_dt_ff};
   assign wait_sat = tick_sum[32] ? tcs_pkg::TIME_MAX : tick_sum[31:0];
   assign fail_inc = (fail_ff != tcs_pkg::FAIL_MAX) ? (fail_ff + 8'd1) : fail_ff;

   // Command sequencer and state update.
   always_comb begin
      seq_in       = seq_ff;
      run_state_in = run_state_ff;
      cur_time_in  = cur_time_ff;
      hold_in      = hold_ff;
      hold_time_in = hold_time_ff;
      wait_in      = wait_ff;
      fail_in      = fail_ff;
      acc_in       = acc_ff;
      do_clear     = 1'b0;
      append_en    = 1'b0;
      clear_en     = 1'b0;
      srch_start   = 1'b0;
      load_rsp     = 1'b0;

      case (seq_ff)
         tcs_pkg::F_IDLE: begin
            if (req.valid) begin
               seq_in = tcs_pkg::F_EXEC;
            end
         end

         tcs_pkg::F_EXEC: begin
            acc_in = 1'b0;
            seq_in = tcs_pkg::F_DONE;
            case (cmd_op_ff)
               tcs_pkg::OP_TICK: begin
                  if (run_state_ff == tcs_pkg::ST_RUNNING) begin
                     acc_in = 1'b1;
                     if (hold_ff) begin
                        wait_in = wait_sat;
                        if (wait_sat > cfg.verify_timeout) begin
                           run_state_in = tcs_pkg::ST_ERROR;
                           hold_in      = 1'b0;
                        end
                     end else if (tick_sum >= {1'b0, cfg.total_duration}) begin
                        cur_time_in  = cfg.total_duration;
                        run_state_in = tcs_pkg::ST_FINISHED;
                     end else begin
                        cur_time_in = tick_sum[31:0];
                        srch_start  = 1'b1;
                        seq_in      = tcs_pkg::F_SEARCH;
                     end
                  end
               end
               tcs_pkg::OP_ARM: begin
                  do_clear     = 1'b1;
                  run_state_in = tcs_pkg::ST_READY;
                  acc_in       = 1'b1;
               end
               tcs_pkg::OP_START: begin
                  if (run_state_ff == tcs_pkg::ST_READY) begin
                     do_clear     = 1'b1;
                     run_state_in = tcs_pkg::ST_RUNNING;
                     acc_in       = 1'b1;
                  end
               end
               tcs_pkg::OP_PAUSE: begin
                  if ((run_state_ff == tcs_pkg::ST_RUNNING) ||
                      (run_state_ff == tcs_pkg::ST_PAUSED)) begin
                     run_state_in = tcs_pkg::ST_PAUSED;
                     acc_in       = 1'b1;
                  end
               end
               tcs_pkg::OP_RESUME: begin
                  if (run_state_ff == tcs_pkg::ST_PAUSED) begin
                     run_state_in = tcs_pkg::ST_RUNNING;
                     acc_in       = 1'b1;
                  end
               end
               tcs_pkg::OP_STOP: begin
                  do_clear     = 1'b1;
                  run_state_in = tcs_pkg::ST_IDLE;
                  acc_in       = 1'b1;
               end
               tcs_pkg::OP_RESET: begin
                  do_clear     = 1'b1;
                  clear_en     = 1'b1;
                  run_state_in = tcs_pkg::ST_IDLE;
                  acc_in       = 1'b1;
               end
               tcs_pkg::OP_PASS: begin
                  if (hold_ff) begin
                     hold_in = 1'b0;
                     fail_in = 8'd0;
                     acc_in  = 1'b1;
                  end
               end
               tcs_pkg::OP_FAIL: begin
                  if (hold_ff) begin
                     cur_time_in = hold_time_ff;
                     fail_in     = fail_inc;
                     acc_in      = 1'b1;
                     if (fail_inc > cfg.fail_limit) begin
                        run_state_in = tcs_pkg::ST_ERROR;
                        hold_in      = 1'b0;
                     end
                  end
               end
               tcs_pkg::OP_APPEND: begin
                  if (!table_full) begin
                     append_en = 1'b1;
                     acc_in    = 1'b1;
                  end
               end
               default: begin
                  acc_in = 1'b0;
               end
            endcase
         end

         tcs_pkg::F_SEARCH: begin
            // Landing exactly on a checkpoint starts a hold.
            if (srch_stat.done) begin
               if (srch_stat.hit) begin
                  hold_in      = 1'b1;
                  hold_time_in = cur_time_ff;
                  wait_in      = 32'd0;
                  fail_in      = 8'd0;
               end
               seq_in = tcs_pkg::F_DONE;
            end
         end

         tcs_pkg::F_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               seq_in   = tcs_pkg::F_IDLE;
            end
         end

         default: begin
            seq_in = tcs_pkg::F_IDLE;
         end
      endcase

      // Arm, start, stop and reset all restart the run from time zero.
      if (do_clear) begin
         cur_time_in  = 32'd0;
         hold_in      = 1'b0;
         hold_time_in = 32'd0;
         wait_in      = 32'd0;
         fail_in      = 8'd0;
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control and run state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= tcs_pkg::F_IDLE;
         run_state_ff <= tcs_pkg::ST_IDLE;
         cur_time_ff  <= 32'd0;
         hold_ff      <= 1'b0;
         hold_time_ff <= 32'd0;
         wait_ff      <= 32'd0;
         fail_ff      <= 8'd0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         run_state_ff <= run_state_in;
         cur_time_ff  <= cur_time_in;
         hold_ff      <= hold_in;
         hold_time_ff <= hold_time_in;
         wait_ff      <= wait_in;
         fail_ff      <= fail_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command word capture.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_op_ff <= req.op;
         cmd_dt_ff <= req.dt;
         cmd_pt_ff <= req.point_time;
      end
   end

   // Output register for the status word.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= run_state_ff;
         rsp_acc_ff    <= acc_ff;
         rsp_wait_ff   <= hold_ff;
         rsp_time_ff   <= cur_time_ff;
         rsp_fail_ff   <= fail_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.run_status = rsp_status_ff;
   assign rsp.accepted   = rsp_acc_ff;
   assign rsp.waiting    = rsp_wait_ff;
   assign rsp.play_time  = rsp_time_ff;
   assign rsp.fail_count = rsp_fail_ff;

   // A hold only exists while the run is active or paused.
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> ((run_state_ff == tcs_pkg::ST_RUNNING) ||
                   (run_state_ff == tcs_pkg::ST_PAUSED)))
      else $error("checkpoint hold outside running or paused state");

   // Failures are only counted at a hold or left behind by an error.
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      (fail_ff != 8'd0) |-> (hold_ff || (run_state_ff == tcs_pkg::ST_ERROR)))
      else $error("failure count set without hold or error");

   // The search unit only finishes while the sequencer waits for it.
   a_search_seq: assert property (@(posedge clock) disable iff (reset)
      srch_stat.done |-> (seq_ff == tcs_pkg::F_SEARCH))
      else $error("search finished outside the search state");

   // Leaving the done state always presents a status word.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      ((seq_ff == tcs_pkg::F_DONE) && (!rsp_valid_ff || rsp.ready)) |=>
      (rsp_valid_ff && (seq_ff == tcs_pkg::F_IDLE)))
      else $error("status word not loaded when leaving done state");

endmodule

FILE: hw/rtl/tcs_csr.sv
// APB-style configuration registers of the trajectory checkpoint sequencer.
module tcs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output tcs_pkg::cfg_type                cfg
);

   logic            wr_en;
   logic [1:0]      reg_idx;
   tcs_pkg::cfg_type cfg_ff, cfg_in;

   // A write completes in the access phase; the port never stalls.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[tcs_pkg::CSR_ADDR_W-1:2];

   // Next register values; writes beyond the map are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            tcs_pkg::REG_TOTAL_DURATION: cfg_in.total_duration = csr_pwdata;
            tcs_pkg::REG_VERIFY_TIMEOUT: cfg_in.verify_timeout = csr_pwdata;
            tcs_pkg::REG_FAIL_LIMIT:     cfg_in.fail_limit     = csr_pwdata[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_duration <= tcs_pkg::TOTAL_DURATION_RST;
         cfg_ff.verify_timeout <= tcs_pkg::VERIFY_TIMEOUT_RST;
         cfg_ff.fail_limit     <= tcs_pkg::FAIL_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (reg_idx)
         tcs_pkg::REG_TOTAL_DURATION: csr_prdata = cfg_ff.total_duration;
         tcs_pkg::REG_VERIFY_TIMEOUT: csr_prdata = cfg_ff.verify_timeout;
         tcs_pkg::REG_FAIL_LIMIT:     csr_prdata = {24'd0, cfg_ff.fail_limit};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/tcs_point_mem.sv
// Checkpoint table with a serial search unit that compares one entry a cycle.
module tcs_point_mem #(
   parameter int MAX_POINTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   append_en,
   input  logic [31:0]            append_data,
   input  logic                   clear_en,
   input  logic                   search_start,
   input  logic [31:0]            search_key,
   output logic                   full,
   output tcs_pkg::srch_stat_type stat
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   logic [31:0]      point_mem [MAX_POINTS];
   logic [31:0]      rd_data_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             active_ff, active_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             hit_ff, hit_in;
   logic             wr_en;
   logic             issue;
   logic             finish;

   assign full   = (count_ff == CNT_MAX);
   assign wr_en  = append_en && !full;
   // A read is issued while entries below the fill count remain.
   assign issue  = active_ff && (idx_ff < count_ff);
   // The search ends once every issued read has been compared.
   assign finish = active_ff && !issue && !cmp_vld_ff;

   // Fill count and search control.
   always_comb begin
      count_in = count_ff;
      if (clear_en) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end

      active_in  = active_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      cmp_vld_in = issue;
      if (search_start) begin
         active_in = 1'b1;
         idx_in    = '0;
         hit_in    = 1'b0;
      end else begin
         if (finish) begin
            active_in = 1'b0;
         end
         if (issue) begin
            idx_in = idx_ff + CNT_W'(1);
         end
         if (cmp_vld_ff && (rd_data_ff == search_key)) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         active_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         active_ff  <= active_in;
         cmp_vld_ff <= cmp_vld_in;
         hit_ff     <= hit_in;
      end
   end

   // Table write port: appends go to the next free entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[count_ff[IDX_W-1:0]] <= append_data;
      end
   end

   // Table read port with registered data.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= point_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign stat.done = finish;
   assign stat.hit  = hit_ff;

endmodule

FILE: bench/tb_top.sv
// Testbench for the trajectory checkpoint sequencer: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb_top;

   localparam int          POINT_SLOTS  = 16;
   localparam int unsigned QUIET_LIMIT  = 5000;
   localparam int unsigned DRAIN_CYCLES = 30;
   // Op codes the block has no use for; they must be refused.
   localparam logic [3:0]  OP_SPARE     = 4'd10;
   localparam logic [3:0]  OP_LAST      = 4'd15;

   // One status word as the block reports it.
   typedef struct packed {
      bit [2:0]  run_status;
      bit        accepted;
      bit        waiting;
      bit [31:0] play_time;
      bit [7:0]  fail_count;
   } status_word_type;

   // Tracks the playback state and keeps the status words still owed by the block.
   class checkpoint_scoreboard;
      bit [31:0]       total_duration;
      bit [31:0]       verify_timeout;
      bit [7:0]        fail_limit;
      bit [2:0]        state;
      bit [31:0]       play_time;
      bit [31:0]       hold_time;
      bit [31:0]       wait_time;
      bit              holding;
      bit [7:0]        failures;
      bit [31:0]       points [POINT_SLOTS];
      int unsigned     npoints;
      status_word_type owed_q [$];
      int unsigned     errors;
      int unsigned     ops_taken;

      function new();
         total_duration = tcs_pkg::TOTAL_DURATION_RST;
         verify_timeout = tcs_pkg::VERIFY_TIMEOUT_RST;
         fail_limit     = tcs_pkg::FAIL_LIMIT_RST;
         state          = tcs_pkg::ST_IDLE;
         npoints        = 0;
         errors         = 0;
         ops_taken      = 0;
         clear_run();
      endfunction

      function void clear_run();
         play_time = '0;
         hold_time = '0;
         wait_time = '0;
         holding   = 1'b0;
         failures  = '0;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            tcs_pkg::REG_TOTAL_DURATION: total_duration = value;
            tcs_pkg::REG_VERIFY_TIMEOUT: verify_timeout = value;
            tcs_pkg::REG_FAIL_LIMIT:     fail_limit = value[7:0];
            default: ;
         endcase
      endfunction

      // Applies one accepted command word and queues the status word it must produce.
      function void note_command(logic [3:0] op, logic [15:0] dt, logic [31:0] pt);
         status_word_type word;
         bit [32:0]       sum;
         bit              taken;
         bit              hit;
         taken = 1'b0;
         case (op)
            tcs_pkg::OP_TICK: if (state == tcs_pkg::ST_RUNNING) begin
               taken = 1'b1;
               if (holding) begin
                  // Time stands still at a checkpoint; only the wait grows.
                  sum = {1'b0, wait_time} + {17'd0, dt};
                  wait_time = sum[32] ? tcs_pkg::TIME_MAX : sum[31:0];
                  if (wait_time > verify_timeout) begin
                     state   = tcs_pkg::ST_ERROR;
                     holding = 1'b0;
                  end
               end else begin
                  sum = {1'b0, play_time} + {17'd0, dt};
                  if (sum >= {1'b0, total_duration}) begin
                     play_time = total_duration;
                     state     = tcs_pkg::ST_FINISHED;
                  end else begin
                     play_time = sum[31:0];
                     hit = 1'b0;
                     for (int i = 0; i < npoints; i++)
                        if (points[i] == play_time) hit = 1'b1;
                     if (hit) begin
                        holding   = 1'b1;
                        hold_time = play_time;
                        wait_time = '0;
                        failures  = '0;
                     end
                  end
               end
            end
            tcs_pkg::OP_ARM: begin
               clear_run();
               state = tcs_pkg::ST_READY;
               taken = 1'b1;
            end
            tcs_pkg::OP_START: if (state == tcs_pkg::ST_READY) begin
               clear_run();
               state = tcs_pkg::ST_RUNNING;
               taken = 1'b1;
            end
            tcs_pkg::OP_PAUSE: if (state == tcs_pkg::ST_RUNNING ||
                                   state == tcs_pkg::ST_PAUSED) begin
               state = tcs_pkg::ST_PAUSED;
               taken = 1'b1;
            end
            tcs_pkg::OP_RESUME: if (state == tcs_pkg::ST_PAUSED) begin
               state = tcs_pkg::ST_RUNNING;
               taken = 1'b1;
            end
            tcs_pkg::OP_STOP: begin
               clear_run();
               state = tcs_pkg::ST_IDLE;
               taken = 1'b1;
            end
            tcs_pkg::OP_RESET: begin
               clear_run();
               state   = tcs_pkg::ST_IDLE;
               npoints = 0;
               taken   = 1'b1;
            end
            tcs_pkg::OP_PASS: if (holding) begin
               holding  = 1'b0;
               failures = '0;
               taken    = 1'b1;
            end
            tcs_pkg::OP_FAIL: if (holding) begin
               // Roll back to the checkpoint; too many misses in a row is fatal.
               play_time = hold_time;
               if (failures != tcs_pkg::FAIL_MAX) failures++;
               if (failures > fail_limit) begin
                  state   = tcs_pkg::ST_ERROR;
                  holding = 1'b0;
               end
               taken = 1'b1;
            end
            tcs_pkg::OP_APPEND: if (npoints < POINT_SLOTS) begin
               points[npoints] = pt;
               npoints++;
               taken = 1'b1;
            end
            default: ;
         endcase
         if (op <= tcs_pkg::OP_APPEND) ops_taken++;
         word.run_status = state;
         word.accepted   = taken;
         word.waiting    = holding;
         word.play_time  = play_time;
         word.fail_count = failures;
         owed_q.push_back(word);
      endfunction

      function void check_status(logic [2:0] got_status, logic got_accepted,
                                 logic got_waiting, logic [31:0] got_time,
                                 logic [7:0] got_fails);
         status_word_type want;
         if (owed_q.size() == 0) begin
            $error("status word arrived with no command outstanding");
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got_status !== want.run_status) begin
            $error("run_status: expected %0d, got %0d", want.run_status, got_status);
            errors++;
         end
         if (got_accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got_accepted);
            errors++;
         end
         if (got_waiting !== want.waiting) begin
            $error("waiting: expected %0d, got %0d", want.waiting, got_waiting);
            errors++;
         end
         if (got_time !== want.play_time) begin
            $error("play_time: expected %0d, got %0d", want.play_time, got_time);
            errors++;
         end
         if (got_fails !== want.fail_count) begin
            $error("fail_count: expected %0d, got %0d", want.fail_count, got_fails);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [tcs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tcs_req_if req_ch ();
   tcs_rsp_if rsp_ch ();

   checkpoint_scoreboard sb;
   int unsigned burst_left = 0;
   bit          offering = 1'b0;
   int unsigned quiet_cycles = 0;

   trajectory_checkpoint_sequencer #(
      .MAX_POINTS(POINT_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always #5 clock = ~clock;

   // Drops valid once and lets the sender sit out the given number of cycles.
   task automatic pause_sender(input int unsigned cycles);
      if (offering) req_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offers one command word, waits for it to be taken, then keeps the burst pacing.
   task automatic send(input logic [3:0] op, input logic [15:0] dt, input logic [31:0] pt);
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.dt         <= dt;
      req_ch.point_time <= pt;
      offering = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_command(op, dt, pt);
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // Register write through setup and access; the caller closes the transfer.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(idx, value);
   endtask

   task automatic configure(input logic [31:0] duration, input logic [31:0] timeout,
                            input logic [7:0] limit);
      write_csr(tcs_pkg::REG_TOTAL_DURATION, duration);
      write_csr(tcs_pkg::REG_VERIFY_TIMEOUT, timeout);
      // Upper bits of the fail limit word are don't-care and get random noise.
      write_csr(tcs_pkg::REG_FAIL_LIMIT, {24'($urandom_range(0, 24'hFF_FFFF)), limit});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Stops offering and waits until every owed status word has come back.
   task automatic drain();
      pause_sender(0);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_noise();
      send(4'($urandom_range(tcs_pkg::OP_TICK, OP_LAST)),
           16'($urandom_range(0, 16'hFFFF)), $urandom);
   endtask

   // One playback run: optional table rebuild, arm (usually) and start, then a mix of
   // ticks, verdicts and pauses steered by the predicted state.
   task automatic play_episode(input int unsigned step, input bit hammer);
      int unsigned k;
      int unsigned moves;
      int unsigned pick;
      if (hammer) begin
         // Land on one checkpoint and fail it until the limit trips.
         send(tcs_pkg::OP_RESET, '0, '0);
         send(tcs_pkg::OP_APPEND, '0, step);
         send(tcs_pkg::OP_ARM, '0, '0);
         send(tcs_pkg::OP_START, '0, '0);
         send(tcs_pkg::OP_TICK, 16'(step), '0);
         while (sb.holding)
            send(tcs_pkg::OP_FAIL, 16'($urandom_range(0, 16'hFFFF)), $urandom);
      end else begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_noise();
         if ($urandom_range(0, 4) == 0)
            send(tcs_pkg::OP_RESET, 16'($urandom_range(0, 16'hFFFF)), $urandom);
         k = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(0, 4);
         repeat (k) begin
            if ($urandom_range(0, 5) == 0)
               send(tcs_pkg::OP_APPEND, 16'($urandom_range(0, 16'hFFFF)), $urandom);
            else
               send(tcs_pkg::OP_APPEND, 16'($urandom_range(0, 16'hFFFF)),
                    step * $urandom_range(1, 40));
         end
         if ($urandom_range(0, 9) != 0) send(tcs_pkg::OP_ARM, '0, '0);
         send(tcs_pkg::OP_START, 16'($urandom_range(0, 16'hFFFF)), '0);
         moves = $urandom_range(8, 30);
         while (moves != 0 && (sb.state == tcs_pkg::ST_RUNNING ||
                               sb.state == tcs_pkg::ST_PAUSED)) begin
            moves--;
            pick = $urandom_range(0, 99);
            if (sb.holding && pick < 80) begin
               if (pick < 40) send(tcs_pkg::OP_FAIL, '0, '0);
               else if (pick < 65) send(tcs_pkg::OP_PASS, '0, '0);
               else send(tcs_pkg::OP_TICK, 16'(step * $urandom_range(0, 2)), '0);
            end else if (sb.state == tcs_pkg::ST_PAUSED) begin
               if (pick < 70) send(tcs_pkg::OP_RESUME, '0, '0);
               else if (pick < 80) send(tcs_pkg::OP_PAUSE, '0, '0);
               else send(tcs_pkg::OP_TICK, 16'(step), '0);
            end else begin
               if (pick < 75)
                  send(tcs_pkg::OP_TICK, 16'(step * $urandom_range(0, 3)), $urandom);
               else if (pick < 85)
                  send(tcs_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)), $urandom);
               else if (pick < 93)
                  send(tcs_pkg::OP_PAUSE, '0, '0);
               else
                  send_noise();
            end
         end
         if ($urandom_range(0, 3) == 0) send(tcs_pkg::OP_STOP, '0, '0);
      end
   endtask

   task automatic random_phase(input int unsigned count, input int unsigned step);
      int unsigned goal;
      goal = sb.ops_taken + count;
      while (sb.ops_taken < goal) play_episode(step, 1'b0);
   endtask

   // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
   initial begin : rsp_sink
      int unsigned hold_left;
      int unsigned mode_left;
      int unsigned mode;
      bit          long_done;
      hold_left = 0;
      mode_left = 0;
      mode      = 0;
      long_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!long_done && sb.ops_taken >= 100) begin
            hold_left = 400;
            long_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ((mode_left % 8) < 5);
            endcase
         end
      end
   end

   // Every status word taken is checked against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_status(rsp_ch.run_status, rsp_ch.accepted, rsp_ch.waiting,
                         rsp_ch.play_time, rsp_ch.fail_count);
   end

   // Watchdog: too long without any word moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      sb = new();
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= tcs_pkg::OP_TICK;
      req_ch.dt         <= '0;
      req_ch.point_time <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: refused commands, pause handling, both verdicts, timeout and fail limit.
      configure(32'd1000, 32'd50, 8'd2);
      send(tcs_pkg::OP_TICK, 16'hFFFF, '0);
      send(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
      send(OP_LAST, '0, '0);
      send(tcs_pkg::OP_APPEND, '0, 32'd100);
      send(tcs_pkg::OP_APPEND, '0, 32'd0);
      send(tcs_pkg::OP_APPEND, '0, 32'hFFFF_FFFF);
      send(tcs_pkg::OP_ARM, '0, '0);
      send(tcs_pkg::OP_START, '0, '0);
      send(tcs_pkg::OP_PAUSE, '0, '0);
      send(tcs_pkg::OP_PAUSE, '0, '0);
      send(tcs_pkg::OP_RESUME, '0, '0);
      send(tcs_pkg::OP_TICK, 16'd100, '0);
      send(tcs_pkg::OP_TICK, 16'd30, '0);
      send(tcs_pkg::OP_FAIL, '0, '0);
      send(tcs_pkg::OP_PASS, '0, '0);
      send(tcs_pkg::OP_TICK, 16'd0, '0);
      send(tcs_pkg::OP_TICK, 16'hFFFF, '0);
      send(tcs_pkg::OP_ARM, '0, '0);
      send(tcs_pkg::OP_START, '0, '0);
      send(tcs_pkg::OP_TICK, 16'd100, '0);
      repeat (3) send(tcs_pkg::OP_FAIL, '0, '0);
      send(tcs_pkg::OP_RESET, '0, '0);
      drain();

      configure(32'd2000, 32'd200, 8'd3);
      random_phase(160, 50);
      drain();

      // A zero-length trajectory finishes on the first tick.
      configure(32'd0, 32'd1, 8'd0);
      random_phase(60, 8);
      drain();

      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd254);
      play_episode(1000, 1'b1);
      random_phase(100, 1000);
      drain();

      configure(32'd500, tcs_pkg::VERIFY_TIMEOUT_RST, tcs_pkg::FAIL_LIMIT_RST);
      random_phase(120, 25);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
